FILE: rtl/prax_pkg.sv
// Shared types, constants and helpers for the point rotation block.
package prax_pkg;

  localparam int ROT_STEPS    = 5;
  localparam int TAYLOR_TERMS = 6;

  localparam logic signed [31:0] Q30_ONE     = 32'sh4000_0000;
  localparam logic [63:0]        ROUND_HALF  = 64'h2000_0000;
  localparam logic [33:0]        HALF_PI_Q30 = 34'd1686629713;
  localparam logic [33:0]        QUARTER_PI  = 34'd843314856;
  // 4 * half pi + quarter pi, keeps the reduced angle argument positive
  localparam logic signed [35:0] ANGLE_OFFSET = 36'sd7589833708;

  typedef enum logic [2:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_START_Z = 3'd2,
    CFG_END_X   = 3'd3,
    CFG_END_Y   = 3'd4,
    CFG_END_Z   = 3'd5,
    CFG_ANGLE   = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_LOAD,
    CS_SCALE,
    CS_SQUARE,
    CS_SQRT,
    CS_DIV_LOAD,
    CS_DIV,
    CS_ANGLE,
    CS_RSQ,
    CS_RSQ_RND,
    CS_TERM_MUL,
    CS_TERM_RND,
    CS_DONE
  } coef_state_e;

  typedef enum logic [2:0] {
    DV_D,
    DV_UX,
    DV_CX,
    DV_SX,
    DV_TERM
  } div_sel_e;

  // Rotation coefficients, all Q30
  typedef struct packed {
    logic              degen;
    logic signed [31:0] cx;
    logic signed [31:0] sx;
    logic signed [31:0] d;
    logic signed [31:0] ux;
    logic signed [31:0] cs;
    logic signed [31:0] sn;
  } coef_t;

  // Coordinate pair (a, b) and untouched coordinate o of each rotation step
  localparam logic [1:0] ROT_A [ROT_STEPS] = '{2'd1, 2'd0, 2'd0, 2'd0, 2'd1};
  localparam logic [1:0] ROT_B [ROT_STEPS] = '{2'd2, 2'd2, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] ROT_O [ROT_STEPS] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd0};

  function automatic logic signed [31:0] rot_c(coef_t k, logic [2:0] r);
    case (r)
      3'd0:    return k.cx;
      3'd1:    return k.d;
      3'd2:    return k.cs;
      3'd3:    return k.d;
      default: return k.cx;
    endcase
  endfunction

  function automatic logic signed [31:0] rot_s(coef_t k, logic [2:0] r);
    case (r)
      3'd0:    return k.sx;
      3'd1:    return k.ux;
      3'd2:    return k.sn;
      3'd3:    return -k.ux;
      default: return -k.sx;
    endcase
  endfunction

  // Taylor divisor: sine (2n)(2n+1), cosine (2n-1)(2n)
  function automatic logic [7:0] taylor_den(logic is_cos, logic [2:0] n);
    logic [7:0] n2;
    n2 = {4'd0, n, 1'b0};
    if (is_cos) return 8'((n2 - 8'd1) * n2);
    return 8'(n2 * (n2 + 8'd1));
  endfunction

endpackage

FILE: rtl/prax_coef.sv
// Sequential unit that derives the rotation coefficients from the axis and angle.
module prax_coef #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [COORD_BITS-1:0] axis_start_i [3],
  input  logic signed [COORD_BITS-1:0] axis_end_i [3],
  input  logic signed [30:0]           angle_i,
  output logic                         busy_o,
  output prax_pkg::coef_t              coef_o
);

  localparam int VW = (COORD_BITS + 1 > 30) ? COORD_BITS + 1 : 30;

  prax_pkg::coef_state_e state_q, state_d;

  logic [VW-1:0]     wmag_q [3];
  logic              wneg_q [3];
  logic [VW-1:0]     big_q;
  logic              degen_q;
  logic [59:0]       sqx_q, sqy_q, sqz_q;
  logic [6:0]        cnt_q;
  logic [63:0]       rt_x_q, rt_res_q, rt_bit_q;
  logic              sqsel_q;
  logic [31:0]       m_q, e_q;
  prax_pkg::div_sel_e dsel_q;
  logic [63:0]       dv_num_q;
  logic [31:0]       dv_rem_q, dv_den_q;
  logic              dv_neg_q;
  logic signed [31:0] d_q, ux_q, cx_q, sx_q;
  logic [33:0]       t_q;
  logic [1:0]        k_q;
  logic signed [31:0] r_q;
  logic [63:0]       prod_q;
  logic [31:0]       r2_q;
  logic signed [31:0] ts_q, tc_q, sr_q, cr_q;
  logic [2:0]        n_q;
  logic              trig_q;
  prax_pkg::coef_t   coef_q;

  // load values
  logic signed [COORD_BITS:0] v_w [3];
  logic [VW-1:0]     vmag_w [3];
  logic [VW-1:0]     vbig_w;
  logic              vzero_w;
  logic signed [35:0] tt_w;

  // shared multiplier
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod_d;

  // divider step
  logic [32:0]       rem_sh;
  logic              dv_ge;
  logic [31:0]       rem_n;
  logic signed [31:0] dv_res;

  // square root step
  logic [63:0]       rt_sum;
  logic              rt_ge;

  logic              scale_hi, scale_lo;
  logic signed [31:0] cur_w;
  logic [31:0]       cur_mag;
  logic [33:0]       term_num;
  logic [31:0]       term_den;
  logic [31:0]       div_den_w;
  logic [63:0]       div_mag_w;
  logic signed [31:0] sn_w, cs_w;
  logic              e_zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_w[i]    = (COORD_BITS+1)'(axis_end_i[i]) - (COORD_BITS+1)'(axis_start_i[i]);
      vmag_w[i] = VW'(v_w[i][COORD_BITS] ? unsigned'(-v_w[i]) : unsigned'(v_w[i]));
    end
    vbig_w = vmag_w[0];
    if (vmag_w[1] > vbig_w) vbig_w = vmag_w[1];
    if (vmag_w[2] > vbig_w) vbig_w = vmag_w[2];
    vzero_w = (v_w[0] == '0) && (v_w[1] == '0) && (v_w[2] == '0);
    tt_w    = (36'(angle_i) <<< 2) + prax_pkg::ANGLE_OFFSET;
  end

  assign scale_hi = (big_q >> 30) != '0;
  assign scale_lo = big_q < VW'(64'h2000_0000);
  assign e_zero   = e_q == '0;

  assign cur_w   = trig_q ? tc_q : ts_q;
  assign cur_mag = cur_w[31] ? unsigned'(-cur_w) : unsigned'(cur_w);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      prax_pkg::CS_SQUARE: begin
        case (cnt_q[1:0])
          2'd0:    mul_a = 32'(wmag_q[0][29:0]);
          2'd1:    mul_a = 32'(wmag_q[1][29:0]);
          2'd2:    mul_a = 32'(wmag_q[2][29:0]);
          default: mul_a = '0;
        endcase
        mul_b = mul_a;
      end
      prax_pkg::CS_RSQ: begin
        mul_a = r_q[31] ? unsigned'(-r_q) : unsigned'(r_q);
        mul_b = mul_a;
      end
      prax_pkg::CS_TERM_MUL: begin
        mul_a = cur_mag;
        mul_b = r2_q;
      end
      default: ;
    endcase
  end

  assign prod_d = 64'(mul_a) * 64'(mul_b);

  assign rem_sh = {dv_rem_q, dv_num_q[63]};
  assign dv_ge  = rem_sh >= {1'b0, dv_den_q};
  assign rem_n  = dv_ge ? 32'(rem_sh - {1'b0, dv_den_q}) : rem_sh[31:0];
  assign dv_res = dv_neg_q ? -signed'(dv_num_q[31:0]) : signed'(dv_num_q[31:0]);

  assign rt_sum = rt_res_q + rt_bit_q;
  assign rt_ge  = rt_x_q >= rt_sum;

  assign term_num = 34'((prod_q + prax_pkg::ROUND_HALF) >> 30);
  assign term_den = 32'(prax_pkg::taylor_den(trig_q, n_q));

  always_comb begin
    case (dsel_q)
      prax_pkg::DV_D: begin
        div_mag_w = 64'(e_q) << 30;
        div_den_w = m_q;
      end
      prax_pkg::DV_UX: begin
        div_mag_w = 64'(wmag_q[0][29:0]) << 30;
        div_den_w = m_q;
      end
      prax_pkg::DV_CX: begin
        div_mag_w = 64'(wmag_q[2][29:0]) << 30;
        div_den_w = e_q;
      end
      default: begin
        div_mag_w = 64'(wmag_q[1][29:0]) << 30;
        div_den_w = e_q;
      end
    endcase
  end

  always_comb begin
    case (k_q)
      2'd0:    begin sn_w = sr_q;  cs_w = cr_q;  end
      2'd1:    begin sn_w = cr_q;  cs_w = -sr_q; end
      2'd2:    begin sn_w = -sr_q; cs_w = -cr_q; end
      default: begin sn_w = -cr_q; cs_w = sr_q;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= prax_pkg::CS_LOAD;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    busy_o  = state_q != prax_pkg::CS_IDLE;
    case (state_q)
      prax_pkg::CS_IDLE: ;
      prax_pkg::CS_LOAD: state_d = vzero_w ? prax_pkg::CS_DONE : prax_pkg::CS_SCALE;
      prax_pkg::CS_SCALE: if (!scale_hi && !scale_lo) state_d = prax_pkg::CS_SQUARE;
      prax_pkg::CS_SQUARE: if (cnt_q == 7'd3) state_d = prax_pkg::CS_SQRT;
      prax_pkg::CS_SQRT: if (rt_bit_q == '0 && sqsel_q) state_d = prax_pkg::CS_DIV_LOAD;
      prax_pkg::CS_DIV_LOAD: begin
        if (dsel_q == prax_pkg::DV_CX && e_zero) state_d = prax_pkg::CS_ANGLE;
        else                                     state_d = prax_pkg::CS_DIV;
      end
      prax_pkg::CS_DIV: begin
        if (cnt_q == 7'd64) begin
          case (dsel_q)
            prax_pkg::DV_SX: state_d = prax_pkg::CS_ANGLE;
            prax_pkg::DV_TERM: begin
              if (trig_q && n_q == 3'(prax_pkg::TAYLOR_TERMS)) state_d = prax_pkg::CS_DONE;
              else                                             state_d = prax_pkg::CS_TERM_MUL;
            end
            default: state_d = prax_pkg::CS_DIV_LOAD;
          endcase
        end
      end
      prax_pkg::CS_ANGLE: if (t_q < prax_pkg::HALF_PI_Q30) state_d = prax_pkg::CS_RSQ;
      prax_pkg::CS_RSQ:      state_d = prax_pkg::CS_RSQ_RND;
      prax_pkg::CS_RSQ_RND:  state_d = prax_pkg::CS_TERM_MUL;
      prax_pkg::CS_TERM_MUL: state_d = prax_pkg::CS_TERM_RND;
      prax_pkg::CS_TERM_RND: state_d = prax_pkg::CS_DIV;
      prax_pkg::CS_DONE:     state_d = prax_pkg::CS_IDLE;
      default:               state_d = prax_pkg::CS_IDLE;
    endcase
    // a register write restarts the computation
    if (start_i) state_d = prax_pkg::CS_LOAD;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      prax_pkg::CS_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          wmag_q[i] <= vmag_w[i];
          wneg_q[i] <= v_w[i][COORD_BITS];
        end
        big_q   <= vbig_w;
        degen_q <= vzero_w;
        t_q     <= tt_w[33:0];
        k_q     <= '0;
      end
      prax_pkg::CS_SCALE: begin
        // normalise magnitudes one bit at a time: shift right (truncating toward zero) or left
        if (scale_hi) begin
          for (int i = 0; i < 3; i++) wmag_q[i] <= wmag_q[i] >> 1;
          big_q <= big_q >> 1;
        end else if (scale_lo) begin
          for (int i = 0; i < 3; i++) wmag_q[i] <= wmag_q[i] << 1;
          big_q <= big_q << 1;
        end
        cnt_q <= '0;
      end
      prax_pkg::CS_SQUARE: begin
        case (cnt_q[1:0])
          2'd0:    sqx_q <= prod_d[59:0];
          2'd1:    sqy_q <= prod_d[59:0];
          2'd2:    sqz_q <= prod_d[59:0];
          default: ;
        endcase
        cnt_q    <= cnt_q + 7'd1;
        rt_x_q   <= 64'(sqx_q) + 64'(sqy_q) + 64'(sqz_q);
        rt_res_q <= '0;
        rt_bit_q <= 64'h4000_0000_0000_0000;
        sqsel_q  <= 1'b0;
      end
      prax_pkg::CS_SQRT: begin
        if (rt_bit_q != '0) begin
          if (rt_ge) begin
            rt_x_q   <= rt_x_q - rt_sum;
            rt_res_q <= (rt_res_q >> 1) + rt_bit_q;
          end else begin
            rt_res_q <= rt_res_q >> 1;
          end
          rt_bit_q <= rt_bit_q >> 2;
        end else if (!sqsel_q) begin
          m_q      <= rt_res_q[31:0];
          rt_x_q   <= 64'(sqy_q) + 64'(sqz_q);
          rt_res_q <= '0;
          rt_bit_q <= 64'h4000_0000_0000_0000;
          sqsel_q  <= 1'b1;
        end else begin
          e_q    <= rt_res_q[31:0];
          dsel_q <= prax_pkg::DV_D;
        end
      end
      prax_pkg::CS_DIV_LOAD: begin
        if (dsel_q == prax_pkg::DV_CX && e_zero) begin
          cx_q <= prax_pkg::Q30_ONE;
          sx_q <= '0;
        end
        dv_num_q <= div_mag_w + 64'(div_den_w >> 1);
        dv_den_q <= div_den_w;
        dv_rem_q <= '0;
        case (dsel_q)
          prax_pkg::DV_UX: dv_neg_q <= wneg_q[0];
          prax_pkg::DV_CX: dv_neg_q <= wneg_q[2];
          prax_pkg::DV_SX: dv_neg_q <= wneg_q[1];
          default:         dv_neg_q <= 1'b0;
        endcase
        cnt_q <= '0;
      end
      prax_pkg::CS_DIV: begin
        if (cnt_q != 7'd64) begin
          dv_num_q <= {dv_num_q[62:0], dv_ge};
          dv_rem_q <= rem_n;
          cnt_q    <= cnt_q + 7'd1;
        end else begin
          case (dsel_q)
            prax_pkg::DV_D:  d_q  <= dv_res;
            prax_pkg::DV_UX: ux_q <= dv_res;
            prax_pkg::DV_CX: cx_q <= dv_res;
            prax_pkg::DV_SX: sx_q <= dv_res;
            default: begin
              if (!trig_q) begin
                ts_q <= dv_res;
                sr_q <= sr_q + dv_res;
              end else begin
                tc_q <= dv_res;
                cr_q <= cr_q + dv_res;
                n_q  <= n_q + 3'd1;
              end
              trig_q <= !trig_q;
            end
          endcase
          if (dsel_q != prax_pkg::DV_TERM) dsel_q <= prax_pkg::div_sel_e'(dsel_q + 3'd1);
        end
      end
      prax_pkg::CS_ANGLE: begin
        // reduce by quarter turns, counting them modulo four
        if (t_q >= prax_pkg::HALF_PI_Q30) begin
          t_q <= t_q - prax_pkg::HALF_PI_Q30;
          k_q <= k_q + 2'd1;
        end else begin
          r_q <= signed'(32'(t_q - prax_pkg::QUARTER_PI));
        end
      end
      prax_pkg::CS_RSQ:      prod_q <= prod_d;
      prax_pkg::CS_RSQ_RND: begin
        r2_q   <= 32'((prod_q + prax_pkg::ROUND_HALF) >> 30);
        ts_q   <= r_q;
        sr_q   <= r_q;
        tc_q   <= prax_pkg::Q30_ONE;
        cr_q   <= prax_pkg::Q30_ONE;
        n_q    <= 3'd1;
        trig_q <= 1'b0;
      end
      prax_pkg::CS_TERM_MUL: prod_q <= prod_d;
      prax_pkg::CS_TERM_RND: begin
        dv_num_q <= 64'(term_num) + 64'(term_den >> 1);
        dv_den_q <= term_den;
        dv_rem_q <= '0;
        dv_neg_q <= !cur_w[31];
        dsel_q   <= prax_pkg::DV_TERM;
        cnt_q    <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{degen: 1'b0, cx: prax_pkg::Q30_ONE, sx: '0, d: prax_pkg::Q30_ONE,
                  ux: '0, cs: prax_pkg::Q30_ONE, sn: '0};
    end else if (state_q == prax_pkg::CS_DONE) begin
      if (degen_q) begin
        coef_q <= '{degen: 1'b1, cx: prax_pkg::Q30_ONE, sx: '0, d: prax_pkg::Q30_ONE,
                    ux: '0, cs: prax_pkg::Q30_ONE, sn: '0};
      end else begin
        coef_q <= '{degen: 1'b0, cx: cx_q, sx: sx_q, d: d_q, ux: ux_q, cs: cs_w, sn: sn_w};
      end
    end
  end

  assign coef_o = coef_q;

endmodule

FILE: rtl/point_rotate_about_axis_top.sv
// Top level: rotates streamed 3D points about a configured axis by a configured angle.
// Throughput one point per cycle while the output is ready and no coefficient recompute runs.
// Pipeline: translate, five rotations of a multiply stage and a round/sum stage, output.
// Coefficients come from a shared multiply/divide/sqrt sequencer that runs after reset
// and after each register write; no point is taken meanwhile.
// Reset (async, active low) empties the pipeline and loads the register defaults.
module point_rotate_about_axis_top #(
  parameter int COORD_BITS = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid_i,
  output logic                                          s_axis_tready_o,
  // point_x, point_y, point_z
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]             s_axis_tdata_i,
  output logic                                          m_axis_tvalid_o,
  input  logic                                          m_axis_tready_i,
  // rotated_x, rotated_y, rotated_z
  output logic [((3*COORD_BITS+7)/8)*8-1:0]             m_axis_tdata_o,
  // axis_degenerate
  output logic                                          m_axis_tuser_o,
  input  logic                                          cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  logic [2:0]                                    cfg_index_i,
  input  logic [((COORD_BITS > 31) ? COORD_BITS : 31)-1:0] cfg_data_i
);

  localparam int CW  = COORD_BITS + 3;
  localparam int PW  = CW + 32;
  localparam int NR  = prax_pkg::ROT_STEPS;
  localparam int NST = 2 * NR + 2;

  logic signed [COORD_BITS-1:0] start_q [3];
  logic signed [COORD_BITS-1:0] end_q [3];
  logic signed [30:0]           angle_q;
  logic                         cfg_we;

  prax_pkg::coef_t coef;
  logic            coef_busy;

  logic [NST-1:0]  vld_q;
  logic [NST:0]    en;

  logic signed [CW-1:0] crd_q [NR+1][3];
  logic signed [CW-1:0] crd_n [NR+1][3];
  logic [PW-1:0]        pm_q [NR][4];
  logic [PW-1:0]        pm_n [NR][4];
  logic                 pn_q [NR][4];
  logic                 pn_n [NR][4];
  logic signed [CW-1:0] po_q [NR];
  logic signed [CW+2:0] qv [NR][4];

  logic [COORD_BITS-1:0] out_q [3];
  logic [COORD_BITS-1:0] out_n [3];
  logic                  deg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        start_q[i] <= '0;
        end_q[i]   <= '0;
      end
      end_q[2] <= COORD_BITS'(65536);
      angle_q  <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        prax_pkg::CFG_START_X: start_q[0] <= cfg_data_i[COORD_BITS-1:0];
        prax_pkg::CFG_START_Y: start_q[1] <= cfg_data_i[COORD_BITS-1:0];
        prax_pkg::CFG_START_Z: start_q[2] <= cfg_data_i[COORD_BITS-1:0];
        prax_pkg::CFG_END_X:   end_q[0]   <= cfg_data_i[COORD_BITS-1:0];
        prax_pkg::CFG_END_Y:   end_q[1]   <= cfg_data_i[COORD_BITS-1:0];
        prax_pkg::CFG_END_Z:   end_q[2]   <= cfg_data_i[COORD_BITS-1:0];
        prax_pkg::CFG_ANGLE:   angle_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  prax_coef #(
    .COORD_BITS(COORD_BITS)
  ) u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cfg_we),
    .axis_start_i(start_q),
    .axis_end_i  (end_q),
    .angle_i     (angle_q),
    .busy_o      (coef_busy),
    .coef_o      (coef)
  );

  // a stage advances when it is empty or the stage after it advances
  always_comb begin
    en[NST] = m_axis_tready_i;
    for (int j = NST - 1; j >= 0; j--) en[j] = !vld_q[j] || en[j+1];
  end

  assign s_axis_tready_o = en[0] && !coef_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid_i && !coef_busy;
      for (int j = 1; j < NST; j++) begin
        if (en[j]) vld_q[j] <= vld_q[j-1];
      end
    end
  end

  always_comb begin
    logic signed [CW-1:0] a, b;
    logic signed [31:0]   c, s;
    logic [CW-1:0]        am, bm;
    logic [31:0]          cm, sm;
    logic [PW-1:0]        rs;
    for (int i = 0; i < 3; i++) begin
      crd_n[0][i] = CW'(signed'(s_axis_tdata_i[i*COORD_BITS +: COORD_BITS]))
                  - CW'(start_q[i]);
    end
    for (int r = 0; r < NR; r++) begin
      a  = crd_q[r][prax_pkg::ROT_A[r]];
      b  = crd_q[r][prax_pkg::ROT_B[r]];
      c  = prax_pkg::rot_c(coef, 3'(r));
      s  = prax_pkg::rot_s(coef, 3'(r));
      am = a[CW-1] ? unsigned'(-a) : unsigned'(a);
      bm = b[CW-1] ? unsigned'(-b) : unsigned'(b);
      cm = c[31] ? unsigned'(-c) : unsigned'(c);
      sm = s[31] ? unsigned'(-s) : unsigned'(s);
      pm_n[r][0] = PW'(am) * PW'(cm);
      pm_n[r][1] = PW'(bm) * PW'(sm);
      pm_n[r][2] = PW'(am) * PW'(sm);
      pm_n[r][3] = PW'(bm) * PW'(cm);
      pn_n[r][0] = a[CW-1] ^ c[31];
      pn_n[r][1] = b[CW-1] ^ s[31];
      pn_n[r][2] = a[CW-1] ^ s[31];
      pn_n[r][3] = b[CW-1] ^ c[31];
      // round half away from zero on the magnitude, then restore the sign
      for (int k = 0; k < 4; k++) begin
        rs       = pm_q[r][k] + PW'(prax_pkg::ROUND_HALF);
        qv[r][k] = signed'((CW+3)'(rs >> 30));
        if (pn_q[r][k]) qv[r][k] = -qv[r][k];
      end
      crd_n[r+1][prax_pkg::ROT_A[r]] = CW'(qv[r][0] - qv[r][1]);
      crd_n[r+1][prax_pkg::ROT_B[r]] = CW'(qv[r][2] + qv[r][3]);
      crd_n[r+1][prax_pkg::ROT_O[r]] = po_q[r];
    end
  end

  always_comb begin
    logic signed [CW:0]            sum;
    logic [CW-COORD_BITS+1:0]      hi;
    for (int i = 0; i < 3; i++) begin
      sum = (CW+1)'(crd_q[NR][i]) + (CW+1)'(start_q[i]);
      hi  = sum[CW:COORD_BITS-1];
      if (hi != '0 && hi != '1) out_n[i] = {sum[CW], {(COORD_BITS-1){!sum[CW]}}};
      else                      out_n[i] = sum[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) crd_q[0] <= crd_n[0];
    for (int r = 0; r < NR; r++) begin
      if (en[2*r+1]) begin
        pm_q[r] <= pm_n[r];
        pn_q[r] <= pn_n[r];
        po_q[r] <= crd_q[r][prax_pkg::ROT_O[r]];
      end
      if (en[2*r+2]) crd_q[r+1] <= crd_n[r+1];
    end
    if (en[NST-1]) begin
      out_q <= out_n;
      deg_q <= coef.degen;
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    for (int i = 0; i < 3; i++) m_axis_tdata_o[i*COORD_BITS +: COORD_BITS] = out_q[i];
  end

  assign m_axis_tvalid_o = vld_q[NST-1];
  assign m_axis_tuser_o  = deg_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !coef_busy)
    else $error("point taken while coefficients are recomputed");

  a_write_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> coef_busy)
    else $error("register write did not restart coefficient unit");

  a_degen_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef.degen |-> coef.sn == '0 && coef.ux == '0 && coef.sx == '0 &&
                   coef.cs == prax_pkg::Q30_ONE)
    else $error("degenerate axis without identity coefficients");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NST-2] && !en[NST-2] |=> vld_q[NST-2])
    else $error("stalled stage lost its item");

endmodule
